FILE: sv/mlfq_scheduler_core_macros.svh
// Assertion macros shared by the scheduler checker.
`ifndef MLFQ_SCHEDULER_CORE_MACROS_SVH
`define MLFQ_SCHEDULER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MLFQ_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("scheduler port check failed");
// Next-cycle implication checked outside reset.
`define MLFQ_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("scheduler port check failed");
`endif

FILE: sv/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;
    localparam int MAX_PROCESSES = 16;
    localparam int MAX_LEVELS    = 8;
    localparam int PID_W = 5;
    localparam int LVL_W = 4;
    localparam int PIDX_W = 4;
    localparam int LIDX_W = 3;
    localparam int FIFO_DEPTH = 2;

    localparam logic [1:0] CFG_NUM_LEVELS    = 2'd0;
    localparam logic [1:0] CFG_NUM_PROCESSES = 2'd1;
    localparam logic [1:0] CFG_BOOST_PERIOD  = 2'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_SLICE = 1'b1;

    localparam logic [2:0] EV_STAY   = 3'd0;
    localparam logic [2:0] EV_DEMOTE = 3'd1;
    localparam logic [2:0] EV_EXIT   = 3'd2;
    localparam logic [2:0] EV_BOOST  = 3'd3;
    localparam logic [2:0] EV_IDLE   = 3'd4;

    localparam logic [1:0] OC_STAY   = 2'd0;
    localparam logic [1:0] OC_DEMOTE = 2'd1;
    localparam logic [1:0] OC_FINISH = 2'd2;
    localparam logic [1:0] OC_UNUSED = 2'd3;

    typedef struct packed {
        logic       command;
        logic [1:0] outcome;
    } in_item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [4:0] process_id;
        logic [3:0] level;
        logic       last;
        logic       all_done;
    } out_item_t;

    typedef struct packed {
        logic [1:0] index;
        logic [15:0] data;
    } cfg_item_t;
endpackage

FILE: sv/mlfq_front.sv
// Input stage: accepts items and queues them for the engine.
`timescale 1ns / 1ps
module mlfq_front
    import mlfq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     q_valid,
    input  logic     q_ready,
    output in_item_t q_item
);
    in_item_t buf_reg [FIFO_DEPTH];
    logic     wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic     push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Store incoming item; fold unused outcome into finished.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg].command <= in_item.command;
            buf_reg[wp_reg].outcome <= in_item.outcome[1] ? OC_FINISH : in_item.outcome;
        end
    end

    // Advance pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: sv/mlfq_engine.sv
// Scheduling engine: queue manipulation and result generation.
`timescale 1ns / 1ps
module mlfq_engine
    import mlfq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_item_t cfg,
    input  logic      q_valid,
    output logic      q_ready,
    input  in_item_t  q_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_SLICE = 5'b00100,
        S_BSCAN = 5'b01000,
        S_BMOVE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]  nl_reg;
    logic [4:0]  np_reg;
    logic [15:0] bp_reg;

    logic [PID_W-1:0] link_mem [MAX_PROCESSES];
    logic [PID_W-1:0] head_reg [MAX_LEVELS];
    logic [PID_W-1:0] tail_reg [MAX_LEVELS];
    logic [15:0] slice_reg;
    logic [4:0]  fin_reg;
    logic [4:0]  loaded_reg;
    logic [3:0]  act_reg;
    logic        started_reg;
    logic [4:0]  ld_pid_reg;
    logic [3:0]  g_reg;
    logic [1:0]  oc_reg;
    logic [PID_W-1:0] lnk_rd_reg;

    out_item_t ob_reg;
    logic      ob_valid_reg;

    assign cfg_ready = 1'b1;
    assign out_valid = ob_valid_reg;
    assign out_item  = ob_reg;

    // Find highest non-empty level among the active ones.
    logic [3:0] top_g;
    logic       top_found;
    always_comb
    begin
        top_g = 4'd0;
        top_found = 1'b0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (4'(i) < act_reg && head_reg[i] != '0)
            begin
                top_g = 4'(i + 1);
                top_found = 1'b1;
            end
        end
    end

    // Highest level at or below g_reg with entries (boost walk from top down).
    logic [3:0] bl_g;
    logic       bl_found;
    always_comb
    begin
        bl_g = 4'd0;
        bl_found = 1'b0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (4'(i + 1) <= g_reg && head_reg[i] != '0)
            begin
                bl_g = 4'(i + 1);
                bl_found = 1'b1;
            end
        end
    end

    logic out_free;
    assign out_free = !ob_valid_reg || out_ready;
    assign q_ready  = (state_reg == S_IDLE) && out_free;

    logic [LIDX_W-1:0] gi, ai, bi, ni;
    assign gi = LIDX_W'(g_reg - 4'd1);
    assign ai = LIDX_W'(act_reg - 4'd1);
    assign bi = LIDX_W'(bl_g - 4'd1);

    logic [PID_W-1:0] pid_s;
    logic [3:0] newlvl;
    logic [4:0] fin_new;
    logic       done_s;
    logic [15:0] slice_inc;
    logic [15:0] period;
    assign pid_s   = head_reg[gi];
    assign newlvl  = (oc_reg == OC_STAY) ? g_reg :
                     (oc_reg == OC_DEMOTE) ? ((g_reg > 4'd1) ? g_reg - 4'd1 : 4'd1) : 4'd0;
    assign ni      = LIDX_W'(newlvl - 4'd1);
    assign fin_new = fin_reg + ((newlvl == 4'd0) ? 5'd1 : 5'd0);
    assign done_s  = (fin_new >= loaded_reg);
    assign slice_inc = slice_reg + 16'd1;
    assign period  = (bp_reg == 16'd0) ? 16'd1 : bp_reg;

    logic [3:0] nl_c;
    logic [4:0] np_c;
    assign nl_c = (nl_reg == 4'd0) ? 4'd1 : (nl_reg > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : nl_reg;
    assign np_c = (np_reg == 5'd0) ? 5'd1 :
                  (np_reg > 5'(MAX_PROCESSES)) ? 5'(MAX_PROCESSES) : np_reg;

    logic [PID_W-1:0] bpid;
    assign bpid = head_reg[bi];

    // Check whether any level below the top holds work once this slice is applied.
    logic low_after;
    always_comb
    begin
        low_after = 1'b0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (4'(i + 1) < act_reg)
            begin
                if (((LIDX_W'(i) == gi) ? (lnk_rd_reg != '0) : (head_reg[i] != '0)) ||
                    (newlvl != 4'd0 && LIDX_W'(i) == ni))
                    low_after = 1'b1;
            end
        end
    end

    logic boost_more;
    assign boost_more = (slice_inc == period) && !done_s && low_after;

    // Check whether more boost items follow the one being moved.
    logic walk_more;
    always_comb
    begin
        walk_more = (lnk_rd_reg != '0);
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (LIDX_W'(i) < bi && head_reg[i] != '0)
                walk_more = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  ;
            S_LOAD:  if (ld_pid_reg == loaded_reg) state_next = S_IDLE;
            S_SLICE: if (out_free) state_next = S_IDLE;
            S_BSCAN: state_next = S_BMOVE;
            S_BMOVE: ;
            default: state_next = S_IDLE;
        endcase
    end

    // Main sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nl_reg <= 4'd3; np_reg <= 5'd1; bp_reg <= 16'd8;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            slice_reg <= '0; fin_reg <= '0; loaded_reg <= '0; act_reg <= '0;
            started_reg <= 1'b0; ld_pid_reg <= '0; g_reg <= '0; oc_reg <= '0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg.index)
                    CFG_NUM_LEVELS:    nl_reg <= cfg.data[3:0];
                    CFG_NUM_PROCESSES: np_reg <= cfg.data[4:0];
                    CFG_BOOST_PERIOD:  bp_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready) ob_valid_reg <= 1'b0;
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        ob_valid_reg <= 1'b1;
                        if (q_item.command == CMD_START)
                        begin
                            for (int i = 0; i < MAX_LEVELS; i++)
                            begin
                                head_reg[i] <= '0;
                                tail_reg[i] <= '0;
                            end
                            act_reg <= nl_c; loaded_reg <= np_c;
                            slice_reg <= '0; fin_reg <= '0; started_reg <= 1'b1;
                            ld_pid_reg <= 5'd1;
                            state_reg <= S_LOAD;
                            ob_reg <= '{EV_IDLE, 5'd0, nl_c, 1'b1, 1'b0};
                        end
                        else if (started_reg && top_found)
                        begin
                            g_reg <= top_g; oc_reg <= q_item.outcome;
                            lnk_rd_reg <= link_mem[PIDX_W'(head_reg[LIDX_W'(top_g - 4'd1)]
                                                   - 5'd1)];
                            ob_valid_reg <= 1'b0;
                            state_reg <= S_SLICE;
                        end
                        else
                            ob_reg <= '{EV_IDLE, 5'd0, 4'd0, 1'b1,
                                        started_reg && (fin_reg >= loaded_reg)};
                    end
                end
                S_LOAD:
                begin
                    // Append one process to the top level per cycle.
                    link_mem[PIDX_W'(ld_pid_reg - 5'd1)] <= '0;
                    if (ld_pid_reg == 5'd1) head_reg[ai] <= ld_pid_reg;
                    else link_mem[PIDX_W'(ld_pid_reg - 5'd2)] <= ld_pid_reg;
                    tail_reg[ai] <= ld_pid_reg;
                    ld_pid_reg <= ld_pid_reg + 5'd1;
                end
                S_SLICE:
                begin
                    if (out_free)
                    begin
                        // Pop head, then requeue per outcome.
                        begin : slc
                            logic hd_empty;
                            hd_empty = (lnk_rd_reg == '0);
                            head_reg[gi] <= lnk_rd_reg;
                            if (hd_empty) tail_reg[gi] <= '0;
                            if (newlvl != 4'd0)
                            begin
                                link_mem[PIDX_W'(pid_s - 5'd1)] <= '0;
                                if (ni == gi ? hd_empty : (head_reg[ni] == '0))
                                    head_reg[ni] <= pid_s;
                                else
                                    link_mem[PIDX_W'(tail_reg[ni] - 5'd1)] <= pid_s;
                                tail_reg[ni] <= pid_s;
                            end
                        end
                        fin_reg <= fin_new;
                        ob_reg <= '{(newlvl == 4'd0) ? EV_EXIT :
                                    (oc_reg == OC_DEMOTE) ? EV_DEMOTE : EV_STAY,
                                    pid_s, newlvl, !boost_more, done_s};
                        ob_valid_reg <= 1'b1;
                        if (slice_inc == period)
                        begin
                            slice_reg <= '0;
                            if (boost_more)
                            begin
                                g_reg <= act_reg - 4'd1;
                                state_reg <= S_BSCAN;
                            end
                        end
                        else
                            slice_reg <= slice_inc;
                    end
                end
                S_BSCAN:
                begin
                    // Settle queue updates; boost walks from level L-1 down.
                    if (bl_found) lnk_rd_reg <= link_mem[PIDX_W'(bpid - 5'd1)];
                    else state_reg <= S_IDLE;
                    g_reg <= bl_found ? bl_g : g_reg;
                end
                S_BMOVE:
                begin
                    if (out_free)
                    begin
                        head_reg[bi] <= lnk_rd_reg;
                        if (lnk_rd_reg == '0) tail_reg[bi] <= '0;
                        link_mem[PIDX_W'(bpid - 5'd1)] <= '0;
                        if (head_reg[ai] == '0) head_reg[ai] <= bpid;
                        else link_mem[PIDX_W'(tail_reg[ai] - 5'd1)] <= bpid;
                        tail_reg[ai] <= bpid;
                        // Mark last when no lower level holds work after this move.
                        ob_reg <= '{EV_BOOST, bpid, act_reg, !walk_more, 1'b0};
                        ob_valid_reg <= 1'b1;
                        state_reg <= S_BSCAN;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: sv/mlfq_scheduler_core.sv
// Top level of the multilevel feedback queue scheduler.
// A slice item takes a head lookup, then a pop and requeue through the link memory;
// a start loads one process per cycle; a boost adds, for each process moved from the
// lower levels, a scan that reads the link of the next process, then the move, plus one
// final scan, and each result waits while the result register is held.
// The result side holds one result register; the input side buffers two items.
`timescale 1ns / 1ps
module mlfq_scheduler_core
    import mlfq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_item_t cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);
    logic     q_valid, q_ready;
    in_item_t q_item;

    mlfq_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    mlfq_engine u_engine (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg(cfg), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );
endmodule

FILE: sv/mlfq_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "mlfq_scheduler_core_macros.svh"
module mlfq_checker
    import mlfq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);
    `MLFQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))
    `MLFQ_ASSERT_IMP(a_ev_range, out_valid, out_item.event_res <= EV_IDLE)
    `MLFQ_ASSERT_IMP(a_boost_nodone, out_valid && out_item.event_res == EV_BOOST, !out_item.all_done)
    `MLFQ_ASSERT_IMP(a_exit_lvl, out_valid && out_item.event_res == EV_EXIT, out_item.level == 4'd0)
endmodule

bind mlfq_scheduler_core mlfq_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item)
);

FILE: dv/mlfq_scheduler_core_tb.sv
// Self-checking testbench of the multilevel feedback queue scheduler core.
`timescale 1ns / 1ps
module mlfq_scheduler_core_tb;
    import mlfq_pkg::*;

    // Scheduler model: tracks the queues and holds the expected results.
    class sched_scoreboard;
        logic [3:0]  cfg_levels;
        logic [4:0]  cfg_procs;
        logic [15:0] cfg_period;
        logic [4:0]  link [MAX_PROCESSES];
        logic [4:0]  head [MAX_LEVELS];
        logic [4:0]  tail [MAX_LEVELS];
        int unsigned slices;
        int unsigned exited;
        int unsigned loaded;
        int unsigned top_level;
        bit          started;
        out_item_t   pending [$];

        function void reset_state();
            cfg_levels = 4'd3;
            cfg_procs  = 5'd1;
            cfg_period = 16'd8;
            foreach (link[i]) link[i] = '0;
            foreach (head[i]) head[i] = '0;
            foreach (tail[i]) tail[i] = '0;
            slices = 0;
            exited = 0;
            loaded = 0;
            top_level = 0;
            started = 0;
            pending.delete();
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_NUM_LEVELS:    cfg_levels = data[3:0];
                CFG_NUM_PROCESSES: cfg_procs  = data[4:0];
                CFG_BOOST_PERIOD:  cfg_period = data;
                default: ;
            endcase
        endfunction

        function void enqueue(int unsigned lvl, int unsigned pid);
            link[pid-1] = '0;
            if (head[lvl-1] == 0)
                head[lvl-1] = pid[4:0];
            else
                link[tail[lvl-1]-1] = pid[4:0];
            tail[lvl-1] = pid[4:0];
        endfunction

        function int unsigned dequeue(int unsigned lvl);
            int unsigned pid;
            pid = head[lvl-1];
            head[lvl-1] = link[pid-1];
            if (head[lvl-1] == 0)
                tail[lvl-1] = '0;
            return pid;
        endfunction

        function void add(logic [2:0] ev, int unsigned pid, int unsigned lvl, bit done);
            out_item_t r;
            r.event_res  = ev;
            r.process_id = pid[4:0];
            r.level      = lvl[3:0];
            r.last       = 1'b1;
            r.all_done   = done;
            pending = {pending, r};
        endfunction

        // Note one accepted input item and predict its results.
        function void note_input(in_item_t it);
            int unsigned g, pid, lvl, per;
            int unsigned first;
            bit done;
            if (it.command == CMD_START) begin
                top_level = (cfg_levels < 1) ? 1 : (cfg_levels > MAX_LEVELS) ? MAX_LEVELS
                                                                              : cfg_levels;
                loaded = (cfg_procs < 1) ? 1 : (cfg_procs > MAX_PROCESSES) ? MAX_PROCESSES
                                                                            : cfg_procs;
                foreach (head[i]) head[i] = '0;
                foreach (tail[i]) tail[i] = '0;
                slices = 0;
                exited = 0;
                started = 1;
                for (int p = 1; p <= loaded; p++)
                    enqueue(top_level, p);
                add(EV_IDLE, 0, top_level, 0);
                return;
            end
            pid = 0;
            g = 0;
            if (started) begin
                for (int l = top_level; l >= 1; l--) begin
                    if (head[l-1] != 0) begin
                        g = l;
                        pid = dequeue(l);
                        break;
                    end
                end
            end
            if (pid == 0) begin
                add(EV_IDLE, 0, 0, started && exited >= loaded);
                return;
            end
            if (it.outcome[1]) begin
                exited++;
                lvl = 0;
            end else if (it.outcome == OC_DEMOTE) begin
                lvl = (g > 1) ? g - 1 : 1;
                enqueue(lvl, pid);
            end else begin
                lvl = g;
                enqueue(lvl, pid);
            end
            done = exited >= loaded;
            add(it.outcome[1] ? EV_EXIT : (it.outcome == OC_DEMOTE ? EV_DEMOTE : EV_STAY),
                pid, lvl, done);
            slices = (slices + 1) & 16'hFFFF;
            per = (cfg_period == 0) ? 1 : cfg_period;
            if (slices == per) begin
                slices = 0;
                if (!done) begin
                    for (int l = top_level - 1; l >= 1; l--) begin
                        while (head[l-1] != 0) begin
                            first = dequeue(l);
                            enqueue(top_level, first);
                            pending[$].last = 1'b0;
                            add(EV_BOOST, first, top_level, 0);
                        end
                    end
                end
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function bit check_result(out_item_t got, output string msg);
            out_item_t exp_r;
            if (pending.size() == 0) begin
                msg = $sformatf("unexpected result %p", got);
                return 0;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                msg = $sformatf("got %p, expected %p", got, exp_r);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    cfg_item_t cfg;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    sched_scoreboard sb;
    int mismatches;

    mlfq_scheduler_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(string msg);
        mismatches++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    // Write one configuration register and update the model; valid stays up for the next write.
    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Send one input item after a random gap; valid drops only during a gap or a drain.
    task automatic send(logic cmd, logic [1:0] oc);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item.command <= cmd;
        in_item.outcome <= oc;
        do @(posedge clk); while (!in_ready);
        sb.note_input('{command: cmd, outcome: oc});
    endtask

    // Hold until every expected result has come, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic setup(logic [15:0] lv, logic [15:0] np, logic [15:0] per);
        drain();
        write_cfg(CFG_NUM_LEVELS, lv);
        write_cfg(CFG_NUM_PROCESSES, np);
        write_cfg(CFG_BOOST_PERIOD, per);
        cfg_valid <= 1'b0;
    endtask

    // Random result-side stall per item.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Check results at each accepting edge.
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && out_ready) begin
            if (!sb.check_result(out_item, msg))
                report(msg);
        end
    end

    initial
    begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int n;
        logic [1:0] oc;
        sb = new();
        sb.reset_state();
        mismatches = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg = '0;
        in_valid = 1'b0;
        in_item = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle slice before any start, then reset defaults.
        send(CMD_SLICE, OC_STAY);
        send(CMD_START, OC_STAY);
        send(CMD_SLICE, OC_DEMOTE);
        send(CMD_SLICE, OC_FINISH);
        send(CMD_SLICE, OC_STAY);
        // Extremes: zero registers clamp, zero period acts as one.
        setup(16'd0, 16'd0, 16'd0);
        send(CMD_START, OC_UNUSED);
        send(CMD_SLICE, OC_DEMOTE);
        send(CMD_SLICE, OC_UNUSED);
        send(CMD_SLICE, OC_STAY);
        // Upper extremes: registers above the max clamp.
        setup(16'd15, 16'd31, 16'hFFFF);
        send(CMD_START, OC_STAY);
        for (int i = 0; i < 6; i++) send(CMD_SLICE, OC_DEMOTE);
        // Full boost: many processes demoted, short period.
        setup(16'd8, 16'd16, 16'd17);
        send(CMD_START, OC_STAY);
        for (int i = 0; i < 17; i++) send(CMD_SLICE, OC_DEMOTE);

        // Random phases with fresh settings.
        n = 0;
        while (n < 500) begin
            setup(16'($urandom_range(0, 15)), 16'($urandom_range(0, 31)),
                  16'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 12)));
            send(CMD_START, 2'($urandom_range(0, 3)));
            n++;
            repeat ($urandom_range(5, 40)) begin
                case ($urandom_range(0, 19))
                    0:       send(CMD_START, 2'($urandom_range(0, 3)));
                    1:       send(CMD_SLICE, OC_UNUSED);
                    2, 3, 4: send(CMD_SLICE, OC_FINISH);
                    default: begin
                        oc = 2'($urandom_range(0, 1));
                        send(CMD_SLICE, oc);
                    end
                endcase
                n++;
            end
        end

        drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    final_check_unused: assert property (@(posedge clk) 1'b1);

    // Leftover expectations at the end make drain() stall; the time limit catches them.
endmodule
